>>> sv/box_filter_3x3_rgb_assert.svh
// assertion macros for the box filter
`ifndef BOX_FILTER_3X3_RGB_ASSERT_SVH
`define BOX_FILTER_3X3_RGB_ASSERT_SVH

// same-cycle implication
`define BF3_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("box filter assertion failed");

// next-cycle implication
`define BF3_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("box filter assertion failed");

`endif

>>> sv/bf3_pkg.sv
package bf3_pkg;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IDX  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IDX = CFG_IDX_W'(1);

  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RST  = WIDTH_REG_W'(640);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RST = HEIGHT_REG_W'(480);

  localparam int unsigned CH_W     = 8;
  localparam int unsigned COLSUM_W = 10;
  localparam int unsigned WINSUM_W = 12;

  // floor(s / 9) == (s * 7282) >> 16 for every window sum
  localparam int unsigned RECIP_W    = 13;
  localparam logic [RECIP_W-1:0] DIV9_RECIP = RECIP_W'(7282);
  localparam int unsigned DIV9_SHIFT = 16;
  localparam int unsigned PROD_W     = WINSUM_W + RECIP_W;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] r;
    logic [COLSUM_W-1:0] g;
    logic [COLSUM_W-1:0] b;
  } colsum_t;

  typedef struct packed {
    logic [WINSUM_W-1:0] r;
    logic [WINSUM_W-1:0] g;
    logic [WINSUM_W-1:0] b;
  } winsum_t;

endpackage

>>> sv/bf3_if.sv
interface bf3_pix_if import bf3_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] pix_red;
  logic [CH_W-1:0] pix_green;
  logic [CH_W-1:0] pix_blue;

  modport source (output valid, output pix_red, output pix_green, output pix_blue,
                  input ready);
  modport sink (input valid, input pix_red, input pix_green, input pix_blue,
                output ready);
endinterface

interface bf3_res_if import bf3_pkg::*; #(
  parameter int COL_W = 10,
  parameter int ROW_W = 12
) ();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;
  logic [CH_W-1:0]  avg_red;
  logic [CH_W-1:0]  avg_green;
  logic [CH_W-1:0]  avg_blue;
  logic             frame_last;

  modport source (output valid, output out_col, output out_row, output avg_red,
                  output avg_green, output avg_blue, output frame_last, input ready);
  modport sink (input valid, input out_col, input out_row, input avg_red,
                input avg_green, input avg_blue, input frame_last, output ready);
endinterface

interface bf3_cfg_if import bf3_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> sv/bf3_ram.sv
module bf3_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bf3_col_cell.sv
module bf3_col_cell import bf3_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  colsum_t col_i,
  input  winsum_t acc_i,
  output colsum_t col_o,
  output winsum_t acc_o
);

  colsum_t col_q;

  // one window column, held as its three channel sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (en_i) begin
      col_q <= col_i;
    end
  end

  assign col_o   = col_q;
  assign acc_o.r = acc_i.r + WINSUM_W'(col_q.r);
  assign acc_o.g = acc_i.g + WINSUM_W'(col_q.g);
  assign acc_o.b = acc_i.b + WINSUM_W'(col_q.b);

endmodule

>>> sv/box_filter_3x3_rgb.sv
// channel   dir  handshake     payload
// pix_i     in   valid/ready   pix_red, pix_green, pix_blue
// res_o     out  valid/ready   out_col, out_row, avg_red/green/blue, frame_last
// cfg_i     in   valid/ready   index, data (always ready)
//
// one pixel item per cycle sustained while res_o takes results; an interior
// pixel's result leaves after the item that completes its window, through the
// line store read, the window sum and the divide by nine into the output register
// the line store port (read at accept, written as stage 1 advances) sets that rate
// reset clears counters, window columns and sizes (640 x 480); no clearing pass
// a stall on res_o backs up through the stages to pix_i.ready
module box_filter_3x3_rgb import bf3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic         clk_i,
  input logic         rst_ni,
  bf3_pix_if.sink     pix_i,
  bf3_res_if.source   res_o,
  bf3_cfg_if.sink     cfg_i
);

  `include "box_filter_3x3_rgb_assert.svh"

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int SZ_W = 18;

  logic [WIDTH_REG_W-1:0]  width_q;
  logic [HEIGHT_REG_W-1:0] height_q;
  logic [SZ_W-1:0]         w_eff;
  logic [SZ_W-1:0]         h_eff;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic          accept;
  logic          emit;
  logic          last;

  logic          s1_valid_q, s1_valid_d;
  pixel_t        s1_cur_q;
  logic [CW-1:0] s1_col_q;
  logic [CW-1:0] s1_colm1_q;
  logic [RW-1:0] s1_rowm1_q;
  logic          s1_emit_q;
  logic          s1_last_q;
  logic          s1_adv;
  logic          s1_free;

  logic          s2_valid_q, s2_valid_d;
  winsum_t       s2_sum_q;
  logic [CW-1:0] s2_col_q;
  logic [RW-1:0] s2_row_q;
  logic          s2_last_q;
  logic          s2_adv;
  logic          s2_free;

  logic          out_valid_q, out_valid_d;
  logic          out_free;
  logic [CW-1:0] out_col_q;
  logic [RW-1:0] out_row_q;
  logic [CH_W-1:0] avg_r_q, avg_g_q, avg_b_q;
  logic          out_last_q;

  pixel_t        top_px;
  pixel_t        mid_px;
  colsum_t       new_col;
  winsum_t       new_acc;
  colsum_t       cell_col [2];
  winsum_t       cell_acc [2];

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;

  // configuration
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_WIDTH_IDX:  width_q  <= cfg_i.data[WIDTH_REG_W-1:0];
        CFG_HEIGHT_IDX: height_q <= cfg_i.data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (SZ_W'(width_q) < SZ_W'(3)) begin
      w_eff = SZ_W'(3);
    end else if (SZ_W'(width_q) > SZ_W'(MAX_WIDTH)) begin
      w_eff = SZ_W'(MAX_WIDTH);
    end else begin
      w_eff = SZ_W'(width_q);
    end
    if (SZ_W'(height_q) < SZ_W'(3)) begin
      h_eff = SZ_W'(3);
    end else if (SZ_W'(height_q) > SZ_W'(MAX_HEIGHT)) begin
      h_eff = SZ_W'(MAX_HEIGHT);
    end else begin
      h_eff = SZ_W'(height_q);
    end
  end

  // handshake across the stages
  assign out_free    = !out_valid_q || res_o.ready;
  assign s2_adv      = s2_valid_q && out_free;
  assign s2_free     = !s2_valid_q || out_free;
  assign s1_adv      = s1_valid_q && s2_free;
  assign s1_free     = !s1_valid_q || s2_free;
  assign pix_i.ready = s1_free;
  assign accept      = pix_i.valid && s1_free;

  // position counters
  always_comb begin
    emit  = (SZ_W'(col_q) >= SZ_W'(2)) && (SZ_W'(row_q) >= SZ_W'(2)) &&
            (SZ_W'(col_q) < w_eff) && (SZ_W'(row_q) < h_eff);
    last  = (SZ_W'(col_q) == w_eff - SZ_W'(1)) && (SZ_W'(row_q) == h_eff - SZ_W'(1));
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (SZ_W'(col_q) + SZ_W'(1) >= w_eff) begin
        col_d = '0;
        if (SZ_W'(row_q) + SZ_W'(1) >= h_eff) begin
          row_d = '0;
        end else begin
          row_d = row_q + RW'(1);
        end
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1: line store read in flight
  assign s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cur_q   <= '{r: pix_i.pix_red, g: pix_i.pix_green, b: pix_i.pix_blue};
      s1_col_q   <= col_q;
      s1_colm1_q <= col_q - CW'(1);
      s1_rowm1_q <= row_q - RW'(1);
      s1_emit_q  <= emit;
      s1_last_q  <= last;
    end
  end

  bf3_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_one (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (s1_cur_q),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (mid_px)
  );

  bf3_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_two (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (mid_px),
    .re_i    (accept),
    .raddr_i (col_q),
    .rdata_o (top_px)
  );

  // newest column sum enters the cell row
  assign new_col.r = COLSUM_W'(top_px.r) + COLSUM_W'(mid_px.r) + COLSUM_W'(s1_cur_q.r);
  assign new_col.g = COLSUM_W'(top_px.g) + COLSUM_W'(mid_px.g) + COLSUM_W'(s1_cur_q.g);
  assign new_col.b = COLSUM_W'(top_px.b) + COLSUM_W'(mid_px.b) + COLSUM_W'(s1_cur_q.b);
  assign new_acc.r = WINSUM_W'(new_col.r);
  assign new_acc.g = WINSUM_W'(new_col.g);
  assign new_acc.b = WINSUM_W'(new_col.b);

  bf3_col_cell u_cell_near (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .col_i  (new_col),
    .acc_i  (new_acc),
    .col_o  (cell_col[0]),
    .acc_o  (cell_acc[0])
  );

  bf3_col_cell u_cell_far (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .col_i  (cell_col[0]),
    .acc_i  (cell_acc[0]),
    .col_o  (cell_col[1]),
    .acc_o  (cell_acc[1])
  );

  // stage 2: window sums
  assign s2_valid_d = s1_adv ? s1_emit_q : (s2_adv ? 1'b0 : s2_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      s2_sum_q  <= cell_acc[1];
      s2_col_q  <= s1_colm1_q;
      s2_row_q  <= s1_rowm1_q;
      s2_last_q <= s1_last_q;
    end
  end

  // output register: divide by nine
  assign prod_r = PROD_W'(s2_sum_q.r) * PROD_W'(DIV9_RECIP);
  assign prod_g = PROD_W'(s2_sum_q.g) * PROD_W'(DIV9_RECIP);
  assign prod_b = PROD_W'(s2_sum_q.b) * PROD_W'(DIV9_RECIP);

  assign out_valid_d = s2_adv ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_col_q  <= s2_col_q;
      out_row_q  <= s2_row_q;
      avg_r_q    <= prod_r[DIV9_SHIFT +: CH_W];
      avg_g_q    <= prod_g[DIV9_SHIFT +: CH_W];
      avg_b_q    <= prod_b[DIV9_SHIFT +: CH_W];
      out_last_q <= s2_last_q;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_col    = out_col_q;
  assign res_o.out_row    = out_row_q;
  assign res_o.avg_red    = avg_r_q;
  assign res_o.avg_green  = avg_g_q;
  assign res_o.avg_blue   = avg_b_q;
  assign res_o.frame_last = out_last_q;

  // read and write of the line stores never meet at one address
  `BF3_ASSERT_NOW(a_ram_no_collide, accept && s1_adv, col_q != s1_col_q)
  // an interior item always reaches the sum stage
  `BF3_ASSERT_NEXT(a_emit_to_s2, s1_adv && s1_emit_q, s2_valid_q)
  // frame end flag only on the last interior column
  `BF3_ASSERT_NOW(a_last_col, res_o.valid && res_o.frame_last,
                  res_o.out_col == CW'(w_eff - SZ_W'(2)))

endmodule

>>> verif/box_filter_3x3_rgb_tb.sv
`timescale 1ns / 1ps

module box_filter_3x3_rgb_tb;
  import bf3_pkg::*;

  localparam int unsigned MAX_W          = 1024;
  localparam int unsigned MAX_H          = 4096;
  localparam int unsigned COL_W          = 10;
  localparam int unsigned ROW_W          = 12;
  localparam int unsigned MIN_DIM        = 3;
  localparam int unsigned WINDOW_PIXELS  = 9;
  localparam int unsigned MAX_IDLE       = 8;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned PROBE_ITEMS    = 20;
  localparam int unsigned WIDE_ITEMS     = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = '1;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    pixel_t           mean;
    logic             last;
  } window_mean_t;

  logic clk_i;
  logic rst_ni;

  bf3_pix_if                                 pix_ch ();
  bf3_res_if #(.COL_W(COL_W), .ROW_W(ROW_W)) res_ch ();
  bf3_cfg_if                                 cfg_ch ();

  box_filter_3x3_rgb #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pix_i (pix_ch),
    .res_o (res_ch),
    .cfg_i (cfg_ch)
  );

  // filter state as seen from outside
  logic [WIDTH_REG_W-1:0]  width_reg  = WIDTH_RST;
  logic [HEIGHT_REG_W-1:0] height_reg = HEIGHT_RST;
  pixel_t                  line_above  [MAX_W];
  pixel_t                  line_above2 [MAX_W];
  pixel_t                  win_cols    [6] = '{default: '0};
  int unsigned             next_col = 0;
  int unsigned             next_row = 0;
  window_mean_t            window_means_q [$];

  pixel_t      pix_q [$];
  bit          tx_busy    = 1'b0;
  bit          px_took    = 1'b0;
  bit          res_took   = 1'b0;
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  bit          hold_arm   = 1'b0;
  bit          hold_on    = 1'b0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;
  int          err_count  = 0;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < MIN_DIM) return MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void predict_window_mean(pixel_t px);
    int unsigned  w, h, c, r, sr, sg, sb;
    pixel_t       top, mid;
    window_mean_t m;
    w   = clamp_dim(width_reg, MAX_W);
    h   = clamp_dim(height_reg, MAX_H);
    c   = next_col;
    r   = next_row;
    top = line_above2[c % MAX_W];
    mid = line_above[c % MAX_W];
    if (c >= 2 && r >= 2 && c < w && r < h) begin
      sr = 0;
      sg = 0;
      sb = 0;
      for (int k = 0; k < 6; k++) begin
        sr += win_cols[k].r;
        sg += win_cols[k].g;
        sb += win_cols[k].b;
      end
      sr += top.r + mid.r + px.r;
      sg += top.g + mid.g + px.g;
      sb += top.b + mid.b + px.b;
      m.col    = COL_W'(c - 1);
      m.row    = ROW_W'(r - 1);
      m.mean.r = CH_W'(sr / WINDOW_PIXELS);
      m.mean.g = CH_W'(sg / WINDOW_PIXELS);
      m.mean.b = CH_W'(sb / WINDOW_PIXELS);
      m.last   = (c == w - 1) && (r == h - 1);
      window_means_q.push_back(m);
    end
    line_above2[c % MAX_W] = mid;
    line_above[c % MAX_W]  = px;
    win_cols[0] = win_cols[3];
    win_cols[1] = win_cols[4];
    win_cols[2] = win_cols[5];
    win_cols[3] = top;
    win_cols[4] = mid;
    win_cols[5] = px;
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
  endfunction

  // pixels left until the counters return to the top left corner
  function automatic int unsigned frame_tail_len();
    int unsigned w, h, c, r, n;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = next_col;
    r = next_row;
    n = 0;
    while (c != 0 || r != 0) begin
      n++;
      if (c + 1 >= w) begin
        c = 0;
        r = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        c++;
      end
    end
    return n;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      err_count++;
    end
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t p;
    p.r = CH_W'($urandom_range(0, 255));
    p.g = CH_W'($urandom_range(0, 255));
    p.b = CH_W'($urandom_range(0, 255));
    // saturated channels now and then
    if ($urandom_range(0, 3) == 0) p.r = {CH_W{p.r[0]}};
    if ($urandom_range(0, 3) == 0) p.g = {CH_W{p.g[0]}};
    if ($urandom_range(0, 3) == 0) p.b = {CH_W{p.b[0]}};
    return p;
  endfunction

  task automatic push_pixels(int unsigned n);
    for (int unsigned k = 0; k < n; k++) pix_q.push_back(random_pixel());
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    while (pix_q.size() != 0 || tx_busy || window_means_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // pixel driver
  always @(negedge clk_i) begin : drive_pixels
    pixel_t nxt;
    if (px_took) begin
      px_took = 1'b0;
      tx_busy = 1'b0;
    end
    if (!tx_busy) begin
      if (tx_gap != 0) begin
        tx_gap--;
        pix_ch.valid <= 1'b0;
      end else if (pix_q.size() != 0) begin
        nxt = pix_q.pop_front();
        pix_ch.pix_red   <= nxt.r;
        pix_ch.pix_green <= nxt.g;
        pix_ch.pix_blue  <= nxt.b;
        pix_ch.valid     <= 1'b1;
        tx_busy = 1'b1;
        tx_gap  = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end else begin
        pix_ch.valid <= 1'b0;
      end
    end
  end

  // result ready
  always @(negedge clk_i) begin
    if (res_took) begin
      res_took = 1'b0;
      rx_gap   = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    end
    if (hold_on || rx_gap != 0) begin
      res_ch.ready <= 1'b0;
      if (!hold_on) rx_gap--;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // long receiver stall so the block backs up into pix_i
  initial begin : rx_hold
    wait (hold_arm);
    @(negedge clk_i);
    hold_on <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(negedge clk_i);
    hold_on <= 1'b0;
  end

  always @(posedge clk_i) begin : track_and_check
    window_mean_t want;
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_WIDTH_IDX) width_reg = cfg_ch.data[WIDTH_REG_W-1:0];
        else if (cfg_ch.index == CFG_HEIGHT_IDX) height_reg = cfg_ch.data[HEIGHT_REG_W-1:0];
      end
      if (pix_ch.valid && pix_ch.ready) begin
        predict_window_mean({pix_ch.pix_red, pix_ch.pix_green, pix_ch.pix_blue});
        px_took = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        res_took = 1'b1;
        if (window_means_q.size() == 0) begin
          $error("unexpected item at col %0d row %0d", res_ch.out_col, res_ch.out_row);
          err_count++;
        end else begin
          want = window_means_q.pop_front();
          check_field("out_col", want.col, res_ch.out_col);
          check_field("out_row", want.row, res_ch.out_row);
          check_field("avg_red", want.mean.r, res_ch.avg_red);
          check_field("avg_green", want.mean.g, res_ch.avg_green);
          check_field("avg_blue", want.mean.b, res_ch.avg_blue);
          check_field("frame_last", want.last, res_ch.frame_last);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned n, wd, hd, sel, done;
    rst_ni           = 1'b0;
    pix_ch.valid     = 1'b0;
    pix_ch.pix_red   = '0;
    pix_ch.pix_green = '0;
    pix_ch.pix_blue  = '0;
    res_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset size, part of the first line
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    push_pixels(PROBE_ITEMS);
    drain();

    // shrink mid-frame, then finish the frame
    cfg_write(CFG_WIDTH_IDX, 16'd5);
    cfg_write(CFG_HEIGHT_IDX, 16'd6);
    push_pixels(frame_tail_len());
    drain();

    // smallest frame, all channels full scale
    cfg_write(CFG_WIDTH_IDX, 16'd3);
    cfg_write(CFG_HEIGHT_IDX, 16'd3);
    repeat (9) pix_q.push_back({3{8'hFF}});
    drain();

    // unused register index must change nothing
    cfg_write(CFG_UNUSED_IDX, 16'hA5A5);
    cfg_write(CFG_WIDTH_IDX, 16'd4);
    cfg_write(CFG_HEIGHT_IDX, 16'd4);
    for (int k = 0; k < 16; k++) pix_q.push_back({8'h00, 8'hFF, CH_W'(k * 17)});
    drain();

    // sizes below the minimum
    cfg_write(CFG_WIDTH_IDX, 16'hF800);
    cfg_write(CFG_HEIGHT_IDX, 16'd1);
    push_pixels(9);
    drain();

    // sizes above the maximum, part of the first line
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    cfg_write(CFG_WIDTH_IDX, 16'h07FF);
    cfg_write(CFG_HEIGHT_IDX, 16'hFFFF);
    push_pixels(WIDE_ITEMS);
    drain();
    cfg_write(CFG_WIDTH_IDX, 16'd3);
    cfg_write(CFG_HEIGHT_IDX, 16'd3);
    push_pixels(frame_tail_len());
    drain();

    // full frame at full rate
    cfg_write(CFG_WIDTH_IDX, 16'd6);
    cfg_write(CFG_HEIGHT_IDX, 16'd5);
    push_pixels(30);
    drain();

    // receiver hold-off
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    cfg_write(CFG_WIDTH_IDX, 16'd4);
    cfg_write(CFG_HEIGHT_IDX, 16'd4);
    push_pixels(120);
    hold_arm = 1'b1;
    drain();

    // random sizes; width grows only at a frame start
    done = 0;
    while (done < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 3);
      if (next_col == 0 && next_row == 0) wd = $urandom_range(0, 12);
      else wd = $urandom_range(0, clamp_dim(width_reg, MAX_W));
      hd = $urandom_range(0, 9);
      if (sel != 2) cfg_write(CFG_WIDTH_IDX, CFG_DATA_W'(wd));
      if (sel != 1) cfg_write(CFG_HEIGHT_IDX, CFG_DATA_W'(hd));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 80);
      push_pixels(n);
      done += n;
      drain();
    end

    if (err_count == 0) begin
      $display("[box_filter_3x3_rgb] OK");
    end else begin
      $display("[box_filter_3x3_rgb] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1ms;
    $display("[box_filter_3x3_rgb] ERROR");
    $finish;
  end

endmodule
